>>> src/lottery_task_scheduler_assert.svh
// Assertion macros used by the checker file.
`ifndef LOTTERY_TASK_SCHEDULER_ASSERT_SVH
`define LOTTERY_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lottery scheduler check failed");

// Next-cycle implication, disabled during reset.
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lottery scheduler check failed");

`endif

>>> src/lts_pkg.sv
`timescale 1ns / 1ps
package lts_pkg;

  localparam int RND_W = 31;
  localparam int ID_W  = 32;
  localparam int TK_W  = 8;

  localparam logic [TK_W-1:0] TICKETS_HIGH_RST   = 8'd100;
  localparam logic [TK_W-1:0] TICKETS_MEDIUM_RST = 8'd50;
  localparam logic [TK_W-1:0] TICKETS_LOW_RST    = 8'd25;

  localparam logic [1:0] CFG_HIGH   = 2'd0;
  localparam logic [1:0] CFG_MEDIUM = 2'd1;
  localparam logic [1:0] CFG_LOW    = 2'd2;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_SCHED  = 1'b1;

  localparam logic [1:0] CLASS_LOW    = 2'd0;
  localparam logic [1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [1:0] CLASS_HIGH   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_DIV,
    ST_SCAN,
    ST_RESULT
  } lts_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic create;
    logic div_step;
    logic scan;
  } lts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic div_last;
    logic scan_done;
  } lts_sts_t;

endpackage

>>> src/lottery_task_scheduler.sv
`timescale 1ns / 1ps
// Lottery task scheduler. A create beat (kind 0) appends a task to a table of
// up to MAX_TASKS entries; its ticket count comes from the register of the
// requested priority class and it gets the next identifier (starts at 1,
// wraps at 2^32). A schedule beat (kind 1) reduces random_value modulo the
// total ticket count plus one and returns the identifier of the first task
// whose running ticket sum reaches that value. Status is 0 ok, 1 table full
// on create (task_id 0), 2 table empty on schedule (task_id 0). One beat is in
// flight at a time. From input beat to result valid, a create writes its table
// entry in the create state; an empty schedule has its result valid in the
// next cycle; a schedule runs the one-bit-per-cycle remainder unit over every
// bit of random_value, then scans the table up to the winning entry (the table
// memory has a registered read port and yields one entry per cycle). The result
// is held until taken, and a new input beat is taken the cycle after. Configuration
// registers (index 0 high, 1 medium, 2 low; other indexes ignored) reset to
// 100, 50 and 25 and may be written only while no beat is pending.
module lottery_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [lts_pkg::TK_W-1:0]  cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [1:0]                priority_req,
  input  logic [lts_pkg::RND_W-1:0] random_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lts_pkg::ID_W-1:0]  task_id,
  output logic [1:0]                status
);
  import lts_pkg::*;

  lts_cmd_t cmd;
  lts_sts_t sts;

  // Sequence the beat: accept, create or divide-then-scan (an empty draw skips both), hold the result.
  lts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the task table, the ticket registers, the remainder unit and the
  // scan accumulator; the result registers drive the output fields directly.
  lts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .priority_req (priority_req),
    .random_value (random_value),
    .task_id      (task_id),
    .status       (status)
  );

endmodule

>>> src/lts_ctrl.sv
`timescale 1ns / 1ps
module lts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             kind,
  output logic             out_valid,
  input  logic             out_ready,
  output lts_pkg::lts_cmd_t cmd,
  input  lts_pkg::lts_sts_t sts
);
  import lts_pkg::*;

  lts_state_t state;
  lts_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (kind == KIND_CREATE) begin
            state_next = ST_CREATE;
          end else if (sts.count_zero) begin
            state_next = ST_RESULT;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_CREATE: begin
        cmd.create = 1'b1;
        state_next = ST_RESULT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/lts_dp.sv
`timescale 1ns / 1ps
module lts_dp #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lts_pkg::lts_cmd_t            cmd,
  output lts_pkg::lts_sts_t            sts,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [lts_pkg::TK_W-1:0]     cfg_data,
  input  logic                         kind,
  input  logic [1:0]                   priority_req,
  input  logic [lts_pkg::RND_W-1:0]    random_value,
  output logic [lts_pkg::ID_W-1:0]     task_id,
  output logic [1:0]                   status
);
  import lts_pkg::*;

  localparam int IW  = $clog2(MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int TW  = $clog2(255 * MAX_TASKS + 2);
  localparam int DCW = $clog2(RND_W);

  logic [TK_W-1:0]  tickets_high;
  logic [TK_W-1:0]  tickets_medium;
  logic [TK_W-1:0]  tickets_low;
  logic [CW-1:0]    count;
  logic [ID_W-1:0]  next_id;
  logic [TW-1:0]    total;
  logic [1:0]       prio;
  logic [RND_W-1:0] dvd;
  logic [TW-1:0]    rem;
  logic [DCW-1:0]   div_cnt;
  logic [IW-1:0]    scan_addr;
  logic [TW-1:0]    run;
  logic             rd_vld;
  logic             rd_last;
  logic [ID_W-1:0]  id_q;
  logic [TK_W-1:0]  tk_q;

  logic [ID_W-1:0]  ids_mem [MAX_TASKS];
  logic [TK_W-1:0]  tk_mem  [MAX_TASKS];

  logic [TK_W-1:0]  class_tk;
  logic             full;
  logic [TW:0]      rem_sh;
  logic [TW:0]      dsr;
  logic [TW:0]      rem_sub;
  logic [TW-1:0]    run_sum;
  logic             hit;
  logic [CW-1:0]    cnt_m1;
  logic [IW-1:0]    last_idx;

  always_comb begin
    unique case (prio)
      CLASS_HIGH:   class_tk = tickets_high;
      CLASS_MEDIUM: class_tk = tickets_medium;
      default:      class_tk = tickets_low;
    endcase
  end

  assign full     = (count == CW'(MAX_TASKS));
  assign cnt_m1   = count - CW'(1);
  assign last_idx = cnt_m1[IW-1:0];

  // one restoring step: remainder of random_value by (total + 1)
  assign rem_sh  = {rem, dvd[RND_W-1]};
  assign dsr     = {1'b0, total} + {{TW{1'b0}}, 1'b1};
  assign rem_sub = rem_sh - dsr;

  assign run_sum = run + {{(TW-TK_W){1'b0}}, tk_q};
  assign hit     = (run_sum >= rem);

  assign sts.count_zero = (count == '0);
  assign sts.div_last   = (div_cnt == DCW'(RND_W - 1));
  assign sts.scan_done  = cmd.scan && rd_vld && (hit || rd_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      tickets_high   <= TICKETS_HIGH_RST;
      tickets_medium <= TICKETS_MEDIUM_RST;
      tickets_low    <= TICKETS_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH:   tickets_high   <= cfg_data;
        CFG_MEDIUM: tickets_medium <= cfg_data;
        CFG_LOW:    tickets_low    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      next_id <= ID_W'(1);
      total   <= '0;
    end else if (cmd.create && !full) begin
      count   <= count + CW'(1);
      next_id <= next_id + ID_W'(1);
      total   <= total + {{(TW-TK_W){1'b0}}, class_tk};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.create && !full) begin
      ids_mem[count[IW-1:0]] <= next_id;
      tk_mem[count[IW-1:0]]  <= class_tk;
    end
    id_q <= ids_mem[scan_addr];
    tk_q <= tk_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prio      <= priority_req;
      dvd       <= random_value;
      rem       <= '0;
      div_cnt   <= '0;
      scan_addr <= '0;
      run       <= '0;
      rd_last   <= 1'b0;
      if (kind == KIND_SCHED) begin
        task_id <= '0;
        status  <= STAT_EMPTY;
      end
    end else if (cmd.div_step) begin
      dvd     <= {dvd[RND_W-2:0], 1'b0};
      rem     <= (rem_sh >= dsr) ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
      div_cnt <= div_cnt + DCW'(1);
    end else if (cmd.create) begin
      if (full) begin
        task_id <= '0;
        status  <= STAT_FULL;
      end else begin
        task_id <= next_id;
        status  <= STAT_OK;
      end
    end else if (cmd.scan) begin
      rd_last <= (scan_addr == last_idx);
      if (scan_addr != last_idx) begin
        scan_addr <= scan_addr + IW'(1);
      end
      if (rd_vld) begin
        run <= run_sum;
        if (hit || rd_last) begin
          task_id <= id_q;
          status  <= STAT_OK;
        end
      end
    end
  end

endmodule

>>> src/lts_checker.sv
`timescale 1ns / 1ps
`include "lottery_task_scheduler_assert.svh"
module lts_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [lts_pkg::ID_W-1:0] task_id,
  input logic [1:0]               status
);
  import lts_pkg::*;

  // a result is held until taken
  `LTS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // one beat at a time: never take input while a result waits
  `LTS_ASSERT_IMPLY(a_one_beat, clk, rst, out_valid, !in_ready)
  // an accepted beat closes the input side
  `LTS_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  // error results carry no identifier
  `LTS_ASSERT_IMPLY(a_err_zero, clk, rst,
    out_valid && (status == STAT_FULL || status == STAT_EMPTY), task_id == '0)
  // only defined status codes appear
  `LTS_ASSERT_IMPLY(a_status_code, clk, rst, out_valid,
    status == STAT_OK || status == STAT_FULL || status == STAT_EMPTY)

endmodule

bind lottery_task_scheduler lts_checker u_lts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .task_id   (task_id),
  .status    (status)
);

>>> tb/sv/tb_lottery_task_scheduler.sv
`timescale 1ns / 1ps
module tb_lottery_task_scheduler;
  import lts_pkg::*;

  localparam int MAX_TASKS      = 16;
  // Cycles without any beat before the run is declared hung. The slowest
  // legal stretch is a sender gap, a full-table draw and a long receiver
  // stall, so this is many times over.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settle time after the last result: one full-table draw with margin.
  localparam int DRAIN_CYCLES   = 60;

  // Register index 3 is decoded by nobody; priority 3 aliases low.
  localparam logic [1:0]       CFG_UNUSED  = 2'd3;
  localparam logic [1:0]       CLASS_ALIAS = 2'd3;
  localparam logic [RND_W-1:0] RND_MAX     = {RND_W{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [1:0]      stat;
  } outcome_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_we       = 1'b0;
  logic [1:0]        cfg_index    = CFG_HIGH;
  logic [TK_W-1:0]   cfg_data     = '0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic              kind         = KIND_CREATE;
  logic [1:0]        priority_req = CLASS_LOW;
  logic [RND_W-1:0]  random_value = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [ID_W-1:0]   task_id;
  logic [1:0]        status;

  lottery_task_scheduler #(.MAX_TASKS(MAX_TASKS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Scheduler mirror: task table, identifier counter and ticket registers
  // ---------------------------------------------------------------------
  logic [ID_W-1:0] slot_id      [MAX_TASKS];
  logic [TK_W-1:0] slot_tickets [MAX_TASKS];
  int unsigned     slot_count   = 0;
  logic [ID_W-1:0] next_id      = 1;
  logic [TK_W-1:0] tk_high      = TICKETS_HIGH_RST;
  logic [TK_W-1:0] tk_medium    = TICKETS_MEDIUM_RST;
  logic [TK_W-1:0] tk_low       = TICKETS_LOW_RST;

  // Outcomes of accepted beats, oldest first.
  outcome_t        expected_outcomes [$];
  int              mismatch_count = 0;
  int              burst_left     = 0;

  function automatic logic [31:0] ticket_total();
    logic [31:0] sum;
    sum = '0;
    for (int i = 0; i < slot_count; i++) sum += slot_tickets[i];
    return sum;
  endfunction

  // Apply one beat to the mirror and return the result it must produce.
  function automatic outcome_t predict_outcome(logic k, logic [1:0] p,
                                               logic [RND_W-1:0] rv);
    outcome_t    o;
    logic [31:0] win;
    logic [31:0] run;
    int          pick;
    o.id   = '0;
    o.stat = STAT_OK;
    if (k == KIND_CREATE) begin
      if (slot_count >= MAX_TASKS) begin
        o.stat = STAT_FULL;
      end else begin
        slot_id[slot_count] = next_id;
        case (p)
          CLASS_HIGH:   slot_tickets[slot_count] = tk_high;
          CLASS_MEDIUM: slot_tickets[slot_count] = tk_medium;
          default:      slot_tickets[slot_count] = tk_low;
        endcase
        slot_count++;
        o.id    = next_id;
        next_id = next_id + 1'b1;
      end
    end else if (slot_count == 0) begin
      o.stat = STAT_EMPTY;
    end else begin
      // Reduce the draw, then take the first task whose running sum reaches it.
      win  = {1'b0, rv} % (ticket_total() + 32'd1);
      run  = '0;
      pick = slot_count - 1;
      for (int i = 0; i < slot_count; i++) begin
        run += slot_tickets[i];
        if (run >= win) begin
          pick = i;
          break;
        end
      end
      o.id = slot_id[pick];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // Send one beat. The sender runs in bursts; at the start of each burst it
  // may drop valid for a random gap. Within a burst valid stays high and only
  // the payload moves, so valid never takes two updates in one step.
  task automatic send_beat(logic k, logic [1:0] p, logic [RND_W-1:0] rv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    kind         <= k;
    priority_req <= p;
    random_value <= rv;
    do @(posedge clk); while (!in_ready);
    expected_outcomes.push_back(predict_outcome(k, p, rv));
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  // Always waits for a clock edge before it returns, so a following beat never
  // raises valid in the step where it was dropped.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0);
  endtask

  // Register write; callers make sure the block is idle first.
  task automatic write_tickets(logic [1:0] idx, logic [TK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_HIGH:   tk_high   = val;
      CFG_MEDIUM: tk_medium = val;
      CFG_LOW:    tk_low    = val;
      default:    ;
    endcase
  endtask

  // Ticket value with the edges of the range favored.
  function automatic logic [TK_W-1:0] pick_tickets();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 8'd1;
      2:       return 8'hFF;
      default: return TK_W'($urandom);
    endcase
  endfunction

  // Draw value: most often 0 to total + 2 so every winner position is hit, plus
  // wide values, offset multiples of total + 1 and the field extremes.
  function automatic logic [RND_W-1:0] draw_value();
    logic [31:0] total;
    total = ticket_total();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return RND_MAX;
      2, 3, 4, 5: return RND_W'($urandom_range(0, total + 2));
      6:          return RND_W'($urandom_range(0, 1000) * (total + 1)
                                + $urandom_range(0, total));
      default:    return RND_W'($urandom);
    endcase
  endfunction

  task automatic retune_tickets();
    wait_for_results();
    write_tickets(CFG_HIGH, pick_tickets());
    write_tickets(CFG_MEDIUM, pick_tickets());
    write_tickets(CFG_LOW, pick_tickets());
    if ($urandom_range(0, 1)) write_tickets(CFG_UNUSED, TK_W'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------
  // Receiver stall pattern: the mode changes every so often between never
  // stalling, short stalls and long stalls.
  int stall_left  = 0;
  int stall_mode  = 0;
  int mode_cycles = 0;

  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  = $urandom_range(0, 2);
      mode_cycles = $urandom_range(20, 150);
    end
    mode_cycles--;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (stall_mode == 1 && $urandom_range(0, 1))
        stall_left = $urandom_range(1, 3);
      else if (stall_mode == 2 && $urandom_range(0, 1))
        stall_left = $urandom_range(5, 24);
    end
  end

  // Compare each result beat with the oldest outcome.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result beat: task_id %h status %0d",
                 $time, task_id, status);
        mismatch_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (task_id !== want.id) begin
          $display("%0t: task_id mismatch: expected %h, actual %h",
                   $time, want.id, task_id);
          mismatch_count++;
        end
        if (status !== want.stat) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.stat, status);
          mismatch_count++;
        end
      end
    end
  end

  // End the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Draws before any task exists must report an empty table.
  task automatic test_empty_table();
    send_beat(KIND_SCHED, CLASS_ALIAS, '0);
    send_beat(KIND_SCHED, CLASS_LOW, RND_MAX);
  endtask

  // Tasks with no tickets: the total is zero, so every draw picks the first.
  task automatic test_zero_tickets();
    wait_for_results();
    write_tickets(CFG_LOW, '0);
    send_beat(KIND_CREATE, CLASS_LOW, RND_MAX);
    send_beat(KIND_SCHED, CLASS_HIGH, RND_MAX);
    send_beat(KIND_SCHED, CLASS_MEDIUM, '0);
    send_beat(KIND_CREATE, CLASS_ALIAS, '0);
    send_beat(KIND_SCHED, CLASS_LOW, 31'd12345);
  endtask

  // Register extremes, the unused index, and draws on the boundaries of the
  // running ticket sums, including a draw that wraps to zero.
  task automatic test_register_extremes();
    wait_for_results();
    write_tickets(CFG_HIGH, 8'hFF);
    write_tickets(CFG_MEDIUM, 8'h01);
    write_tickets(CFG_UNUSED, 8'hFF);
    write_tickets(CFG_LOW, 8'hAA);
    send_beat(KIND_CREATE, CLASS_HIGH, '0);
    send_beat(KIND_CREATE, CLASS_MEDIUM, '0);
    send_beat(KIND_CREATE, CLASS_ALIAS, RND_MAX);
    send_beat(KIND_SCHED, CLASS_LOW, 31'd1);
    send_beat(KIND_SCHED, CLASS_LOW, 31'd255);
    send_beat(KIND_SCHED, CLASS_LOW, 31'd256);
    send_beat(KIND_SCHED, CLASS_LOW, RND_W'(ticket_total()));
    send_beat(KIND_SCHED, CLASS_LOW, RND_W'(ticket_total() + 1));
  endtask

  // Fill the table under changing ticket settings, then push past full.
  task automatic test_fill_table();
    while (slot_count < MAX_TASKS) begin
      retune_tickets();
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 2) == 0)
          send_beat(KIND_CREATE, 2'($urandom), RND_W'($urandom));
        else
          send_beat(KIND_SCHED, 2'($urandom), draw_value());
      end
    end
    repeat (3) send_beat(KIND_CREATE, 2'($urandom), RND_W'($urandom));
  endtask

  // Long random run on the full table, mostly draws; hold for every result
  // now and then and rewrite the registers while idle.
  task automatic test_random_draws();
    for (int n = 0; n < 1000; n++) begin
      if (n % 250 == 249) retune_tickets();
      if ($urandom_range(0, 6) == 0)
        send_beat(KIND_CREATE, 2'($urandom), RND_W'($urandom));
      else
        send_beat(KIND_SCHED, 2'($urandom), draw_value());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_zero_tickets();
    test_register_extremes();
    test_fill_table();
    test_random_draws();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> lottery_task_scheduler.f
+incdir+src
src/lts_pkg.sv
src/lts_ctrl.sv
src/lts_dp.sv
src/lottery_task_scheduler.sv
src/lts_checker.sv
tb/sv/tb_lottery_task_scheduler.sv
